// ===== sv/dlpt_pkg.sv =====
// ----------------------------------------------------------------------------
// dlpt_pkg
// Types and constants shared by the dispatch load pattern tracker.
// ----------------------------------------------------------------------------
package dlpt_pkg;

    localparam int REG_ID_W = 8;
    localparam int ADDR_W   = 64;

    typedef enum logic [1:0] {
        OP_CAND_LOAD   = 2'd0,
        OP_OTHER_LOAD  = 2'd1,
        OP_OR          = 2'd2,
        OP_OFFSET_LOAD = 2'd3
    } t_opcode;

    // One input event as it arrives on the port.
    typedef struct packed {
        logic [1:0]          opcode;
        logic [REG_ID_W-1:0] reg_id;
        logic [ADDR_W-1:0]   instr_address;
        logic [ADDR_W-1:0]   read_address;
    } t_event;

    // One reported load.
    typedef struct packed {
        logic [ADDR_W-1:0] found_read_address;
        logic [ADDR_W-1:0] found_instr_offset;
    } t_result;

    // Classified command handed from the front end to the list engine.
    typedef struct packed {
        t_opcode             opcode;
        logic [REG_ID_W-1:0] reg_id;
        logic [ADDR_W-1:0]   read_address;
        logic [ADDR_W-1:0]   instr_offset;
    } t_cmd;

    // Front end to back end handshake.
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_chan;

endpackage

// ===== sv/dlpt_front.sv =====
// ----------------------------------------------------------------------------
// dlpt_front
// Accepts events, folds the register id, forms the instruction offset and
// queues the resulting command for the list engine.
// ----------------------------------------------------------------------------
module dlpt_front #(
    parameter int REG_ID_COUNT = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  dlpt_pkg::t_event            i_cmd,
    input  logic                        i_cfg_valid,
    input  logic [dlpt_pkg::ADDR_W-1:0] i_cfg_data,
    input  logic                        i_pop,
    output dlpt_pkg::t_cmd_chan         o_head
);

    localparam int RegW     = (REG_ID_COUNT >= 2**dlpt_pkg::REG_ID_W) ?
                              dlpt_pkg::REG_ID_W : $clog2(REG_ID_COUNT);
    localparam int MapDepth = 2**dlpt_pkg::REG_ID_W;
    localparam int QDepth   = 2;
    localparam int QIdxW    = 1;
    localparam int QCntW    = 2;

    logic [dlpt_pkg::ADDR_W-1:0] r_module_base;
    dlpt_pkg::t_cmd              r_q [QDepth];
    logic [QIdxW-1:0]            r_wr;
    logic [QIdxW-1:0]            r_rd;
    logic [QCntW-1:0]            r_cnt;
    logic [QCntW-1:0]            n_cnt;
    logic [RegW-1:0]             w_reg_map [MapDepth];
    dlpt_pkg::t_cmd              w_new;
    logic                        w_push;

    // Register id folding table, fixed at elaboration.
    for (genvar g = 0; g < MapDepth; g++) begin : g_map
        assign w_reg_map[g] = RegW'(g % REG_ID_COUNT);
    end

    assign busy   = (r_cnt == QCntW'(QDepth));
    assign w_push = start && !busy;

    always_comb begin
        w_new.opcode       = dlpt_pkg::t_opcode'(i_cmd.opcode);
        w_new.reg_id       = dlpt_pkg::REG_ID_W'(w_reg_map[i_cmd.reg_id]);
        w_new.read_address = i_cmd.read_address;
        w_new.instr_offset = i_cmd.instr_address - r_module_base;
    end

    always_comb begin
        n_cnt = r_cnt;
        if (w_push && !i_pop) begin
            n_cnt = r_cnt + QCntW'(1);
        end else if (!w_push && i_pop) begin
            n_cnt = r_cnt - QCntW'(1);
        end
    end

    assign o_head.valid = (r_cnt != '0);
    assign o_head.cmd   = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_module_base <= '0;
            r_wr          <= '0;
            r_rd          <= '0;
            r_cnt         <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_module_base <= i_cfg_data;
            end
            if (w_push) begin
                r_wr <= r_wr + QIdxW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QIdxW'(1);
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_new;
        end
    end

endmodule

// ===== sv/dlpt_back.sv =====
// ----------------------------------------------------------------------------
// dlpt_back
// Ordered register list engine: one command retired per cycle, oldest entry
// at position zero, removals close the gap by shifting the tail down.
// ----------------------------------------------------------------------------
module dlpt_back #(
    parameter int LIST_DEPTH   = 16,
    parameter int REG_ID_COUNT = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dlpt_pkg::t_cmd_chan i_head,
    output logic                o_pop,
    output logic                o_strobe,
    output dlpt_pkg::t_result   o_result
);

    localparam int RegW = (REG_ID_COUNT >= 2**dlpt_pkg::REG_ID_W) ?
                          dlpt_pkg::REG_ID_W : $clog2(REG_ID_COUNT);
    localparam int CntW = $clog2(LIST_DEPTH + 1);
    localparam int IdxW = $clog2(LIST_DEPTH);
    localparam int AW   = dlpt_pkg::ADDR_W;

    logic [RegW-1:0] r_reg  [LIST_DEPTH];
    logic [AW-1:0]   r_addr [LIST_DEPTH];
    logic [AW-1:0]   r_off  [LIST_DEPTH];
    logic            r_mark [LIST_DEPTH];
    logic [CntW-1:0] r_count;
    logic [CntW-1:0] n_count;
    logic            r_phase;
    logic            n_phase;
    logic            r_strobe;
    logic            n_strobe;
    dlpt_pkg::t_result r_result;
    dlpt_pkg::t_result n_result;

    dlpt_pkg::t_cmd        w_cmd;
    logic [RegW-1:0]       w_reg;
    logic [LIST_DEPTH-1:0] w_valid;
    logic [LIST_DEPTH-1:0] w_match;
    logic [LIST_DEPTH-1:0] w_prefix;
    logic [LIST_DEPTH-1:0] w_marked;
    logic [LIST_DEPTH-1:0] w_first;
    logic [LIST_DEPTH-1:0] w_shift;
    logic                  w_hit;
    logic                  w_full;
    logic                  w_drop;
    logic [AW-1:0]         w_hit_addr;
    logic [AW-1:0]         w_hit_off;
    logic [AW-1:0]         w_mk_addr;
    logic [AW-1:0]         w_mk_off;
    logic [CntW-1:0]       w_base_cnt;
    logic                  w_wr_en;
    logic [IdxW-1:0]       w_wr_idx;
    logic [AW-1:0]         w_wr_addr;
    logic [AW-1:0]         w_wr_off;
    logic                  w_wr_mark;

    assign w_cmd = i_head.cmd;
    assign w_reg = w_cmd.reg_id[RegW-1:0];
    assign o_pop = i_head.valid;

    // Per-entry match, oldest-match prefix and oldest-mark select.
    always_comb begin
        w_hit_addr = '0;
        w_hit_off  = '0;
        w_mk_addr  = '0;
        w_mk_off   = '0;
        for (int i = 0; i < LIST_DEPTH; i++) begin
            w_valid[i]  = (CntW'(i) < r_count);
            w_match[i]  = w_valid[i] && (r_reg[i] == w_reg);
            w_marked[i] = w_valid[i] && r_mark[i];
        end
        for (int i = 0; i < LIST_DEPTH; i++) begin
            w_prefix[i] = 1'b0;
            w_first[i]  = w_marked[i];
            for (int j = 0; j < LIST_DEPTH; j++) begin
                if (j <= i) begin
                    w_prefix[i] = w_prefix[i] | w_match[j];
                end
                if (j < i) begin
                    w_first[i] = w_first[i] & ~w_marked[j];
                end
            end
            w_hit_addr = w_hit_addr | ({AW{w_match[i]}} & r_addr[i]);
            w_hit_off  = w_hit_off  | ({AW{w_match[i]}} & r_off[i]);
            w_mk_addr  = w_mk_addr  | ({AW{w_first[i]}} & r_addr[i]);
            w_mk_off   = w_mk_off   | ({AW{w_first[i]}} & r_off[i]);
        end
    end

    assign w_hit  = |w_match;
    assign w_full = (r_count == CntW'(LIST_DEPTH));

    // Command decode.
    always_comb begin
        n_count    = r_count;
        n_phase    = r_phase;
        n_strobe   = 1'b0;
        n_result   = r_result;
        w_drop     = 1'b0;
        w_shift    = '0;
        w_wr_en    = 1'b0;
        w_base_cnt = r_count - CntW'(w_hit);
        w_wr_addr  = w_cmd.read_address;
        w_wr_off   = w_cmd.instr_offset;
        w_wr_mark  = 1'b0;
        if (i_head.valid) begin
            case (w_cmd.opcode)
                dlpt_pkg::OP_CAND_LOAD: begin
                    // Full with no entry of its own: drop the oldest first.
                    w_drop     = !w_hit && w_full;
                    w_shift    = w_prefix | {LIST_DEPTH{w_drop}};
                    w_base_cnt = r_count - CntW'(w_hit) - CntW'(w_drop);
                    w_wr_en    = 1'b1;
                    n_count    = w_base_cnt + CntW'(1);
                    n_phase    = 1'b0;
                end
                dlpt_pkg::OP_OTHER_LOAD: begin
                    w_shift = w_prefix;
                    n_count = w_base_cnt;
                    n_phase = 1'b0;
                end
                dlpt_pkg::OP_OR: begin
                    if (w_hit) begin
                        // Move the entry to the back, marked.
                        w_shift   = w_prefix;
                        w_wr_en   = 1'b1;
                        w_wr_addr = w_hit_addr;
                        w_wr_off  = w_hit_off;
                        w_wr_mark = 1'b1;
                        n_phase   = 1'b1;
                    end
                end
                dlpt_pkg::OP_OFFSET_LOAD: begin
                    if (!r_phase) begin
                        n_count = '0;
                    end else if (|w_marked) begin
                        n_strobe                    = 1'b1;
                        n_result.found_read_address = w_mk_addr;
                        n_result.found_instr_offset = w_mk_off;
                        n_count                     = '0;
                    end
                end
                default: begin
                    n_count = r_count;
                end
            endcase
        end
        w_wr_idx = w_base_cnt[IdxW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_phase  <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_phase  <= n_phase;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        for (int i = 0; i < LIST_DEPTH; i++) begin
            if (w_wr_en && (w_wr_idx == IdxW'(i))) begin
                r_reg[i]  <= w_reg;
                r_addr[i] <= w_wr_addr;
                r_off[i]  <= w_wr_off;
                r_mark[i] <= w_wr_mark;
            end else if (w_shift[i] && (i < LIST_DEPTH - 1)) begin
                r_reg[i]  <= r_reg[(i < LIST_DEPTH - 1) ? i + 1 : i];
                r_addr[i] <= r_addr[(i < LIST_DEPTH - 1) ? i + 1 : i];
                r_off[i]  <= r_off[(i < LIST_DEPTH - 1) ? i + 1 : i];
                r_mark[i] <= r_mark[(i < LIST_DEPTH - 1) ? i + 1 : i];
            end
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

// ===== sv/dispatch_load_pattern_tracker_core.sv =====
// ----------------------------------------------------------------------------
// dispatch_load_pattern_tracker_core
// Tracks per-register loads and OR marks, and reports the oldest marked load
// when an offset load follows an OR.
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------
//  event    | start, busy (accept when  | i_cmd   (dlpt_pkg::t_event)
//           |  start && !busy)          |
//  result   | o_strobe, one cycle       | o_result (dlpt_pkg::t_result)
//  config   | i_cfg_valid, o_cfg_ready  | i_cfg_data (module_base)
//
// One event per cycle while busy is low. The front end's offset subtract and
// queue register each command, and the list engine, which retires one command
// each cycle, registers the result.
// busy rises only when the two-entry command queue is full; since the list
// engine drains it every cycle, it stays low in normal operation.
// Reset is synchronous and empties the list and the queue at once.
// Results cannot be held off: each o_strobe transfer is one cycle wide.
// ----------------------------------------------------------------------------
module dispatch_load_pattern_tracker_core #(
    parameter int LIST_DEPTH   = 16,
    parameter int REG_ID_COUNT = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  dlpt_pkg::t_event            i_cmd,
    output logic                        o_strobe,
    output dlpt_pkg::t_result           o_result,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [dlpt_pkg::ADDR_W-1:0] i_cfg_data
);

    dlpt_pkg::t_cmd_chan w_head;
    logic                w_pop;

    assign o_cfg_ready = 1'b1;

    dlpt_front #(
        .REG_ID_COUNT(REG_ID_COUNT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_cmd      (i_cmd),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .i_pop      (w_pop),
        .o_head     (w_head)
    );

    dlpt_back #(
        .LIST_DEPTH  (LIST_DEPTH),
        .REG_ID_COUNT(REG_ID_COUNT)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

endmodule

// ===== sv/dlpt_checker.sv =====
// ----------------------------------------------------------------------------
// dlpt_checker
// Port-level checks for the dispatch load pattern tracker.
// ----------------------------------------------------------------------------
module dlpt_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input dlpt_pkg::t_event i_cmd,
    input logic             o_strobe
);

    logic w_acc;
    assign w_acc = start && !busy;

    // A report empties the list, so the next event cannot report again.
    a_no_double_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("two results in consecutive cycles");

    // Every result is caused by an offset load transfer, through the command queue and result registers.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($past(w_acc, 2) &&
                      ($past(i_cmd.opcode, 2) == dlpt_pkg::OP_OFFSET_LOAD)))
        else $error("result without a matching offset load");

    // A candidate load ends the OR phase: an offset load right after it is silent.
    a_cand_clears_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(w_acc && (i_cmd.opcode == dlpt_pkg::OP_CAND_LOAD)) && w_acc &&
         (i_cmd.opcode == dlpt_pkg::OP_OFFSET_LOAD)) |=> ##1 !o_strobe)
        else $error("report after a candidate load");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe)
        else $error("result strobe right after reset");

endmodule

bind dispatch_load_pattern_tracker_core dlpt_checker u_dlpt_checker (.*);

// ===== test/tb_dispatch_load_pattern_tracker_core.sv =====
// ----------------------------------------------------------------------------
// tb_dispatch_load_pattern_tracker_core
// Drives classified instruction events into the tracker under several module
// base settings and checks every reported load against a tracked copy of the
// per-register list, OR marks and OR phase.
// ----------------------------------------------------------------------------
module tb_dispatch_load_pattern_tracker_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_DEPTH   = 16;
    localparam int REG_ID_COUNT = 256;
    localparam int DRAIN_CYCLES = 4;
    localparam int STALL_LIMIT  = 1000;
    localparam int PHASE_ITEMS  = 300;
    localparam int AW           = dlpt_pkg::ADDR_W;
    localparam int RW           = dlpt_pkg::REG_ID_W;
    localparam logic [AW-1:0] ALL_ONES = '1;

    class t_load_tracker_sb;
        typedef struct {
            logic [RW-1:0] reg_id;
            logic [AW-1:0] load_addr;
            logic [AW-1:0] instr_offset;
            bit            or_mark;
        } t_track_entry;

        t_track_entry      track_q[$];
        dlpt_pkg::t_result found_q[$];
        bit                or_phase;
        logic [AW-1:0]     module_base;
        int                mismatches;
        int                event_cnt;
        int                found_cnt;
        int                base_cnt;

        function new();
            module_base = '0;
        endfunction

        function void set_base(logic [AW-1:0] value);
            module_base = value;
            base_cnt++;
        endfunction

        function int find_reg(logic [RW-1:0] rid);
            for (int i = 0; i < track_q.size(); i++)
                if (track_q[i].reg_id == rid)
                    return i;
            return -1;
        endfunction

        // Append at the back; a full list drops its oldest entry.
        function void add_entry(t_track_entry e);
            track_q.insert(track_q.size(), e);
            if (track_q.size() > LIST_DEPTH)
                void'(track_q.pop_front());
        endfunction

        function void note_event(dlpt_pkg::t_event ev);
            t_track_entry      e;
            dlpt_pkg::t_result r;
            int                pos;
            event_cnt++;
            pos = find_reg(ev.reg_id);
            case (dlpt_pkg::t_opcode'(ev.opcode))
                dlpt_pkg::OP_CAND_LOAD: begin
                    if (pos >= 0)
                        track_q.delete(pos);
                    e.reg_id       = ev.reg_id;
                    e.load_addr    = ev.read_address;
                    e.instr_offset = ev.instr_address - module_base;
                    e.or_mark      = 1'b0;
                    add_entry(e);
                    or_phase = 1'b0;
                end
                dlpt_pkg::OP_OTHER_LOAD: begin
                    if (pos >= 0)
                        track_q.delete(pos);
                    or_phase = 1'b0;
                end
                dlpt_pkg::OP_OR: begin
                    if (pos >= 0) begin
                        e = track_q[pos];
                        track_q.delete(pos);
                        e.or_mark = 1'b1;
                        add_entry(e);
                        or_phase = 1'b1;
                    end
                end
                dlpt_pkg::OP_OFFSET_LOAD: begin
                    if (!or_phase) begin
                        track_q.delete();
                    end else begin
                        // scan from the back so the oldest marked entry wins
                        pos = -1;
                        for (int i = track_q.size() - 1; i >= 0; i--)
                            if (track_q[i].or_mark)
                                pos = i;
                        if (pos >= 0) begin
                            r.found_read_address = track_q[pos].load_addr;
                            r.found_instr_offset = track_q[pos].instr_offset;
                            found_q.insert(found_q.size(), r);
                            found_cnt++;
                            track_q.delete();
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] MISMATCH: %s", $time, msg);
            mismatches++;
        endtask

        task check_result(dlpt_pkg::t_result got);
            dlpt_pkg::t_result want;
            if (found_q.size() == 0) begin
                report_mismatch($sformatf("unexpected load report addr=%h offset=%h",
                                          got.found_read_address, got.found_instr_offset));
                return;
            end
            want = found_q.pop_front();
            if (got.found_read_address !== want.found_read_address)
                report_mismatch($sformatf("found_read_address got %h want %h",
                                          got.found_read_address, want.found_read_address));
            if (got.found_instr_offset !== want.found_instr_offset)
                report_mismatch($sformatf("found_instr_offset got %h want %h",
                                          got.found_instr_offset, want.found_instr_offset));
        endtask
    endclass

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              start       = 1'b0;
    logic              busy;
    dlpt_pkg::t_event  i_cmd       = '0;
    logic              o_strobe;
    dlpt_pkg::t_result o_result;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [AW-1:0]     i_cfg_data  = '0;

    t_load_tracker_sb sb = new();
    bit               quiet;
    int               stall_cnt;
    int               sent_total;

    always #2 i_clk = ~i_clk;

    dispatch_load_pattern_tracker_core #(
        .LIST_DEPTH  (LIST_DEPTH),
        .REG_ID_COUNT(REG_ID_COUNT)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_cmd      (i_cmd),
        .o_strobe   (o_strobe),
        .o_result   (o_result),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    // Transfers on all three channels, plus the stall watchdog.
    always @(posedge i_clk) begin : mon
        bit moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (o_strobe) begin
                sb.check_result(o_result);
                moved = 1'b1;
            end
            if (start && !busy) begin
                sb.note_event(i_cmd);
                moved = 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                sb.set_base(i_cfg_data);
                moved = 1'b1;
            end
        end
        stall_cnt = moved ? 0 : stall_cnt + 1;
        if (stall_cnt >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [AW-1:0] rand_addr();
        return {$urandom, $urandom};
    endfunction

    function automatic dlpt_pkg::t_event make_event(dlpt_pkg::t_opcode op,
                                                    logic [RW-1:0] rid,
                                                    logic [AW-1:0] ia,
                                                    logic [AW-1:0] ra);
        dlpt_pkg::t_event ev;
        ev.opcode        = op;
        ev.reg_id        = rid;
        ev.instr_address = ia;
        ev.read_address  = ra;
        return ev;
    endfunction

    task automatic send_event(dlpt_pkg::t_event ev);
        if (!quiet && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) @(negedge i_clk) start <= 1'b0;
        @(negedge i_clk);
        start <= 1'b1;
        i_cmd <= ev;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sent_total++;
    endtask

    task automatic send_random(dlpt_pkg::t_opcode op, logic [RW-1:0] rid);
        send_event(make_event(op, rid, rand_addr(), rand_addr()));
    endtask

    // Drop start, wait for every pending report, then let the pipe empty.
    task automatic settle();
        @(negedge i_clk) start <= 1'b0;
        while (sb.found_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_base(logic [AW-1:0] value);
        if (!quiet)
            repeat ($urandom_range(0, 3)) @(negedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk) i_cfg_valid <= 1'b0;
    endtask

    // Mostly load / OR / offset-load runs over a small register pool, with
    // some fully random events mixed in.
    task automatic run_traffic(int n_items);
        logic [RW-1:0] pool [20];
        int            target;
        int            pool_n;
        int            len;
        bit            long_run;
        logic [RW-1:0] rid;
        target = sent_total + n_items;
        while (sent_total < target) begin
            if ($urandom_range(0, 4) == 0) begin
                send_random(dlpt_pkg::t_opcode'($urandom_range(0, 3)),
                            RW'($urandom_range(0, 255)));
            end else begin
                long_run = ($urandom_range(0, 9) == 0);
                pool_n   = long_run ? $urandom_range(17, 20) : $urandom_range(1, 6);
                len      = long_run ? pool_n + $urandom_range(0, 3) : $urandom_range(1, 8);
                foreach (pool[i])
                    pool[i] = RW'($urandom_range(0, 255));
                for (int k = 0; k < len; k++) begin
                    rid = long_run ? pool[k % pool_n] : pool[$urandom_range(0, pool_n - 1)];
                    send_random(($urandom_range(0, 3) == 0) ? dlpt_pkg::OP_OTHER_LOAD :
                                                              dlpt_pkg::OP_CAND_LOAD, rid);
                end
                repeat ($urandom_range(1, 3))
                    send_random(dlpt_pkg::OP_OR, pool[$urandom_range(0, pool_n - 1)]);
                // occasionally break the OR phase before the offset load
                if ($urandom_range(0, 4) == 0)
                    send_random(($urandom_range(0, 1) == 0) ? dlpt_pkg::OP_OTHER_LOAD :
                                                              dlpt_pkg::OP_CAND_LOAD,
                                pool[$urandom_range(0, pool_n - 1)]);
                send_random(dlpt_pkg::OP_OFFSET_LOAD, RW'($urandom_range(0, 255)));
                if ($urandom_range(0, 5) == 0)
                    send_random(dlpt_pkg::OP_OFFSET_LOAD, RW'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin : stim
        logic [AW-1:0] base;
        quiet = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // Base at the top of the address space: offsets wrap.
        write_base(ALL_ONES);
        send_random(dlpt_pkg::OP_CAND_LOAD, 8'h5A);
        send_random(dlpt_pkg::OP_OFFSET_LOAD, 8'h5A);   // no OR phase: list is emptied
        send_event(make_event(dlpt_pkg::OP_CAND_LOAD, 8'h00, '0, '0));
        send_event(make_event(dlpt_pkg::OP_CAND_LOAD, 8'hFF, ALL_ONES, ALL_ONES));
        send_random(dlpt_pkg::OP_OTHER_LOAD, 8'h00);
        send_random(dlpt_pkg::OP_OR, 8'hFF);
        send_event(make_event(dlpt_pkg::OP_OFFSET_LOAD, 8'hFF, ALL_ONES, ALL_ONES));
        // overflow: the first of seventeen candidates falls off the front
        for (int i = 0; i < LIST_DEPTH + 1; i++)
            send_random(dlpt_pkg::OP_CAND_LOAD, RW'(8'h10 + i));
        send_random(dlpt_pkg::OP_OR, 8'h10);
        send_random(dlpt_pkg::OP_OR, 8'h20);
        send_random(dlpt_pkg::OP_OFFSET_LOAD, 8'h00);
        settle();

        for (int p = 0; p < 6; p++) begin
            quiet = (p == 5);
            case (p)
                0:       base = '0;
                2:       base = ALL_ONES;
                4:       base = {1'b1, {(AW - 1){1'b0}}};
                default: base = rand_addr();
            endcase
            write_base(base);
            run_traffic(PHASE_ITEMS);
            settle();
        end

        if (sb.found_q.size() != 0)
            sb.report_mismatch($sformatf("%0d load reports never arrived", sb.found_q.size()));
        $display("Ran %0d events over %0d module base settings; %0d loads were reported.",
                 sb.event_cnt, sb.base_cnt, sb.found_cnt);
        if (sb.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
